// ===== hw/rtl/assert_macros.svh =====
// assertion helpers used by signed_divider_registers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every rising clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/sdiv_pkg.sv =====
package sdiv_pkg;

   localparam int DATA_W = 64;
   localparam int HALF_W = 32;
   localparam int CNT_W  = 6;

   // request commands
   localparam logic [1:0] CMD_MODE = 2'd0;
   localparam logic [1:0] CMD_NUM  = 2'd1;
   localparam logic [1:0] CMD_DEN  = 2'd2;

   // divide modes
   localparam logic [1:0] MODE_32_32 = 2'd0;
   localparam logic [1:0] MODE_64_64 = 2'd2;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_PREP = 5'b00010,
      ST_DIV  = 5'b00100,
      ST_FIX  = 5'b01000,
      ST_DONE = 5'b10000
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } core_stat_type;

   function automatic logic [DATA_W-1:0] sext32(input logic [DATA_W-1:0] v);
      return {{(DATA_W-HALF_W){v[HALF_W-1]}}, v[HALF_W-1:0]};
   endfunction

endpackage

// ===== hw/rtl/sdiv_ifs.sv =====
interface sdiv_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] command;
   logic [2:0] byte_lane;
   logic [7:0] write_data;

   modport source (output valid, output command, output byte_lane, output write_data,
                   input ready);
   modport sink (input valid, input command, input byte_lane, input write_data,
                 output ready);
endinterface

interface sdiv_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [63:0] quotient;
   logic signed [63:0] remainder;
   logic               divide_by_zero;

   modport source (output valid, output quotient, output remainder, output divide_by_zero,
                   input ready);
   modport sink (input valid, input quotient, input remainder, input divide_by_zero,
                 output ready);
endinterface

// ===== hw/rtl/signed_divider_registers.sv =====
// signed divider behind a byte-wide register write port
// req channel: one request writes the 2-bit mode (command 0), one byte of the
//   64-bit numerator (command 1) or one byte of the denominator (command 2),
//   byte_lane selecting the byte; command 3 writes nothing
// rsp channel: one response per request carrying the held quotient and
//   remainder plus the divide_by_zero flag (full 64-bit denominator is zero)
// mode 0 is 32/32 with sign-extended results, modes 1 and 3 are 64/32,
//   mode 2 is 64/64; a zero divisor keeps the previous results
// request path: a nonzero divisor passes through operand preparation,
//   the radix-2 divider core retiring one quotient bit per cycle, the
//   sign fix and the output stage; a zero divisor goes straight from
//   preparation to the done state and the output stage
// one request at a time: req ready is high only while idle, so a new
//   request is taken only after the previous result has left the done state
// a response waits in the output register while the receiver stalls; the
//   next request is taken meanwhile and its result waits in the done state
// reset (synchronous) clears mode, operands and held results to zero and
//   empties the output register
`include "assert_macros.svh"

module signed_divider_registers (
   input  logic               clock,
   input  logic               reset,
   sdiv_req_if.sink           req_bus,
   sdiv_rsp_if.source         rsp_bus
);

   localparam int W = sdiv_pkg::DATA_W;

   // architectural registers
   sdiv_pkg::state_type  state_ff, state_in;
   logic [1:0]           mode_ff, mode_in;
   logic [W-1:0]         num_ff, num_in;
   logic [W-1:0]         den_ff, den_in;
   logic [W-1:0]         quo_held_ff, quo_held_in;
   logic [W-1:0]         rem_held_ff, rem_held_in;

   // operand signs for the final correction
   logic                 nneg_ff, nneg_in;
   logic                 dneg_ff, dneg_in;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [W-1:0]         rsp_quo_ff, rsp_quo_in;
   logic [W-1:0]         rsp_rem_ff, rsp_rem_in;
   logic                 rsp_dbz_ff, rsp_dbz_in;

   // operand preparation
   logic [W-1:0]         n_op, d_op;
   logic [W-1:0]         n_mag, d_mag;
   logic                 div_zero;
   logic                 core_start;

   // sign correction
   logic [W-1:0]         core_quo, core_rem;
   logic [W-1:0]         q_signed, r_signed;

   sdiv_pkg::core_stat_type core_stat;

   logic                 req_fire;
   logic                 rsp_free;

   assign req_bus.ready = (state_ff == sdiv_pkg::ST_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign rsp_free      = !rsp_valid_ff || rsp_bus.ready;

   // pick operands by mode, 32-bit halves are sign extended
   always_comb begin
      n_op     = (mode_ff == sdiv_pkg::MODE_32_32) ? sdiv_pkg::sext32(num_ff) : num_ff;
      d_op     = (mode_ff == sdiv_pkg::MODE_64_64) ? den_ff : sdiv_pkg::sext32(den_ff);
      div_zero = (mode_ff == sdiv_pkg::MODE_64_64) ? (den_ff == '0)
                                                   : (den_ff[sdiv_pkg::HALF_W-1:0] == '0);
      n_mag    = n_op[W-1] ? (~n_op + 1'b1) : n_op;
      d_mag    = d_op[W-1] ? (~d_op + 1'b1) : d_op;
   end

   assign core_start = (state_ff == sdiv_pkg::ST_PREP) && !div_zero;

   sdiv_core u_core (
      .clock     (clock),
      .reset     (reset),
      .start     (core_start),
      .dividend  (n_mag),
      .divisor   (d_mag),
      .quotient  (core_quo),
      .remainder (core_rem),
      .status    (core_stat)
   );

   // quotient negative when signs differ, remainder follows the numerator;
   // the most negative value over -1 wraps naturally here
   always_comb begin
      q_signed = (nneg_ff ^ dneg_ff) ? (~core_quo + 1'b1) : core_quo;
      r_signed = nneg_ff ? (~core_rem + 1'b1) : core_rem;
   end

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      quo_held_in  = quo_held_ff;
      rem_held_in  = rem_held_ff;
      nneg_in      = nneg_ff;
      dneg_in      = dneg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_quo_in   = rsp_quo_ff;
      rsp_rem_in   = rsp_rem_ff;
      rsp_dbz_in   = rsp_dbz_ff;

      case (state_ff)
         sdiv_pkg::ST_IDLE: begin
            if (req_fire) begin
               case (req_bus.command)
                  sdiv_pkg::CMD_MODE: begin
                     mode_in = req_bus.write_data[1:0];
                  end
                  sdiv_pkg::CMD_NUM: begin
                     num_in[{req_bus.byte_lane, 3'b000} +: 8] = req_bus.write_data;
                  end
                  sdiv_pkg::CMD_DEN: begin
                     den_in[{req_bus.byte_lane, 3'b000} +: 8] = req_bus.write_data;
                  end
                  default: begin
                     // unused command, registers unchanged
                  end
               endcase
               state_in = sdiv_pkg::ST_PREP;
            end
         end
         sdiv_pkg::ST_PREP: begin
            // zero divisor keeps held results
            nneg_in  = n_op[W-1];
            dneg_in  = d_op[W-1];
            state_in = div_zero ? sdiv_pkg::ST_DONE : sdiv_pkg::ST_DIV;
         end
         sdiv_pkg::ST_DIV: begin
            if (core_stat.done) begin
               state_in = sdiv_pkg::ST_FIX;
            end
         end
         sdiv_pkg::ST_FIX: begin
            if (mode_ff == sdiv_pkg::MODE_32_32) begin
               quo_held_in = sdiv_pkg::sext32(q_signed);
               rem_held_in = sdiv_pkg::sext32(r_signed);
            end else begin
               quo_held_in = q_signed;
               rem_held_in = r_signed;
            end
            state_in = sdiv_pkg::ST_DONE;
         end
         sdiv_pkg::ST_DONE: begin
            // hand over once the output register is free
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_quo_in   = quo_held_ff;
               rsp_rem_in   = rem_held_ff;
               rsp_dbz_in   = (den_ff == '0);
               state_in     = sdiv_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sdiv_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sdiv_pkg::ST_IDLE;
         mode_ff      <= '0;
         num_ff       <= '0;
         den_ff       <= '0;
         quo_held_ff  <= '0;
         rem_held_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         num_ff       <= num_in;
         den_ff       <= den_in;
         quo_held_ff  <= quo_held_in;
         rem_held_ff  <= rem_held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      nneg_ff    <= nneg_in;
      dneg_ff    <= dneg_in;
      rsp_quo_ff <= rsp_quo_in;
      rsp_rem_ff <= rsp_rem_in;
      rsp_dbz_ff <= rsp_dbz_in;
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.quotient       = rsp_quo_ff;
   assign rsp_bus.remainder      = rsp_rem_ff;
   assign rsp_bus.divide_by_zero = rsp_dbz_ff;

   // divider core runs only while the sequencer waits on it
   `ASSERT_ALWAYS(a_core_busy_in_div, clock, reset,
      !core_stat.busy || (state_ff == sdiv_pkg::ST_DIV), "core busy outside divide state")

   // a new response only comes out of the done state
   `ASSERT_ALWAYS(a_rsp_from_done, clock, reset,
      !$rose(rsp_valid_ff) || $past(state_ff == sdiv_pkg::ST_DONE),
      "response raised outside done state")

   // held results change only in the sign fix step
   `ASSERT_NEXT(a_held_only_in_fix, clock, reset,
      state_ff != sdiv_pkg::ST_FIX, $stable(quo_held_ff) && $stable(rem_held_ff),
      "held results changed outside fix state")

   // an accepted request always moves on to operand preparation
   `ASSERT_NEXT(a_fire_to_prep, clock, reset,
      req_fire, state_ff == sdiv_pkg::ST_PREP, "accepted request did not start preparation")

endmodule

// ===== hw/rtl/sdiv_core.sv =====
module sdiv_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [sdiv_pkg::DATA_W-1:0]  dividend,
   input  logic [sdiv_pkg::DATA_W-1:0]  divisor,
   output logic [sdiv_pkg::DATA_W-1:0]  quotient,
   output logic [sdiv_pkg::DATA_W-1:0]  remainder,
   output sdiv_pkg::core_stat_type      status
);

   localparam int W = sdiv_pkg::DATA_W;
   localparam logic [sdiv_pkg::CNT_W-1:0] LAST = sdiv_pkg::CNT_W'(W - 1);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [sdiv_pkg::CNT_W-1:0]    cnt_ff, cnt_in;
   logic [W-1:0]                  quo_ff, quo_in;
   logic [W-1:0]                  rem_ff, rem_in;
   logic [W-1:0]                  div_ff, div_in;
   logic [W:0]                    diff;

   // one quotient bit per cycle, dividend bits shift out the top of quo_ff
   assign diff = {rem_ff, quo_ff[W-1]} - {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         if (!diff[W]) begin
            rem_in = diff[W-1:0];
         end else begin
            rem_in = {rem_ff[W-2:0], quo_ff[W-1]};
         end
         quo_in = {quo_ff[W-2:0], ~diff[W]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign quotient    = quo_ff;
   assign remainder   = rem_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule
